>>> hw/rtl/dept_pkg.sv
// dept_pkg: widths, event codes and shared types of the dual encoder period tachometer
// no dependencies; imported by every other rtl file
`default_nettype none

package dept_pkg;

   localparam int TIMER_BITS  = 16;
   localparam int AVERAGE_LEN = 6;

   localparam int FUNC_W    = 2;
   localparam int CAP_W     = 16;
   localparam int CAP_USE_W = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;
   localparam int STOP_W    = 20;
   localparam int RUN_W     = 21;
   localparam int PER_W     = 22;
   localparam int SUM_W     = 24;
   localparam int EDGE_W    = 32;
   localparam int FILL_W    = $clog2(AVERAGE_LEN + 1);
   localparam int RUN_EXT_W = ((TIMER_BITS + 1 > RUN_W) ? TIMER_BITS + 1 : RUN_W) + 2;

   localparam logic [STOP_W-1:0] STOP_RESET = STOP_W'(1000000);
   localparam logic signed [RUN_EXT_W-1:0] OVF_STEP = RUN_EXT_W'(64'd1 << TIMER_BITS);
   localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(AVERAGE_LEN - 1);

   // divide by AVERAGE_LEN as multiply by rounded-up reciprocal, exact for SUM_W-bit magnitudes
   localparam int AVG_SHIFT = SUM_W + $clog2(AVERAGE_LEN);
   localparam int RECIP_W   = SUM_W + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVERAGE_LEN) - 64'd1) / 64'(AVERAGE_LEN));

   typedef enum logic [FUNC_W-1:0] {
      FUNC_OVERFLOW = 2'd0,
      FUNC_RIGHT    = 2'd1,
      FUNC_LEFT     = 2'd2
   } func_type;

   typedef struct packed {
      logic signed [PER_W-1:0] period;
      logic [EDGE_W-1:0]       edges;
      logic signed [SUM_W-1:0] sum;
      logic                    fresh;
   } chan_snap_type;

endpackage

`default_nettype wire

>>> hw/rtl/dept_ifs.sv
// dept_req_if and dept_rsp_if: valid/ready channels of the tachometer
// depends on dept_pkg
`default_nettype none

interface dept_req_if;
   import dept_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [CAP_W-1:0]     capture_value;
   modport source (output valid, func, capture_value, input ready);
   modport sink   (input valid, func, capture_value, output ready);
endinterface

interface dept_rsp_if;
   import dept_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [PER_W-1:0] period_right;
   logic signed [PER_W-1:0] average_right;
   logic                    average_new_right;
   logic [EDGE_W-1:0]       edges_right;
   logic signed [PER_W-1:0] period_left;
   logic signed [PER_W-1:0] average_left;
   logic                    average_new_left;
   logic [EDGE_W-1:0]       edges_left;
   modport source (output valid, period_right, average_right, average_new_right,
                   edges_right, period_left, average_left, average_new_left,
                   edges_left, input ready);
   modport sink   (input valid, period_right, average_right, average_new_right,
                   edges_right, period_left, average_left, average_new_left,
                   edges_left, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dual_encoder_period_tachometer_top.sv
// dual_encoder_period_tachometer_top: two-wheel encoder period meter with six-period average
// depends on dept_pkg, dept_ifs, dept_channel, dept_avg_div
//
//  channel   direction  transfer               payload
//  req_chan  in         valid && ready         func, capture_value
//  rsp_chan  out        valid && ready         period/average/average_new/edges per wheel
//  csr       in         csr_we high at edge    csr_wdata = stop_limit
//
// one item per cycle while rsp_chan.ready stays high; a result passes the stage 1 and stage 2
// registers after its request transfer before it shows on rsp_chan
// stage 1 updates channel state at the request transfer, stage 2 does the reciprocal divide
// reset clears channel state, valid flags and averages, stop_limit returns to 1000000
// a stalled result holds; one more item waits in stage 1, then req_chan.ready drops
`default_nettype none

module dual_encoder_period_tachometer_top (
   input  logic                        clock,
   input  logic                        reset,
   dept_req_if.sink                    req_chan,
   dept_rsp_if.source                  rsp_chan,
   input  logic                        csr_we,
   input  logic [dept_pkg::STOP_W-1:0] csr_wdata
);
   import dept_pkg::*;

   logic [STOP_W-1:0]       stop_ff;
   logic                    s_valid_ff, s_valid_in;
   logic                    o_valid_ff, o_valid_in;
   chan_snap_type           snap_r, snap_l;
   chan_snap_type           snap_r_ff, snap_l_ff;
   logic signed [PER_W-1:0] div_r, div_l;
   logic signed [PER_W-1:0] period_r_ff, avg_r_ff, period_l_ff, avg_l_ff;
   logic                    new_r_ff, new_l_ff;
   logic [EDGE_W-1:0]       edges_r_ff, edges_l_ff;

   logic                    accept;
   logic                    o_load;
   logic                    ev_ovf, ev_right, ev_left;

   assign o_load         = s_valid_ff && (!o_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s_valid_ff || o_load;
   assign accept         = req_chan.valid && req_chan.ready;

   assign ev_ovf   = (req_chan.func == FUNC_OVERFLOW);
   assign ev_right = (req_chan.func == FUNC_RIGHT);
   assign ev_left  = (req_chan.func == FUNC_LEFT);

   dept_channel u_right (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .ovf        (ev_ovf),
      .hit        (ev_right),
      .cap        (req_chan.capture_value[CAP_USE_W-1:0]),
      .stop_limit (stop_ff),
      .snap       (snap_r)
   );

   dept_channel u_left (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .ovf        (ev_ovf),
      .hit        (ev_left),
      .cap        (req_chan.capture_value[CAP_USE_W-1:0]),
      .stop_limit (stop_ff),
      .snap       (snap_l)
   );

   dept_avg_div u_div_r (.sum(snap_r_ff.sum), .average(div_r));
   dept_avg_div u_div_l (.sum(snap_l_ff.sum), .average(div_l));

   always_comb begin
      s_valid_in = s_valid_ff;
      if (accept) begin
         s_valid_in = 1'b1;
      end else if (o_load) begin
         s_valid_in = 1'b0;
      end
      o_valid_in = o_valid_ff;
      if (o_load) begin
         o_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff    <= STOP_RESET;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         avg_r_ff   <= '0;
         avg_l_ff   <= '0;
      end else begin
         if (csr_we) begin
            stop_ff <= csr_wdata;
         end
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
         if (o_load && snap_r_ff.fresh) begin
            avg_r_ff <= div_r;
         end
         if (o_load && snap_l_ff.fresh) begin
            avg_l_ff <= div_l;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         snap_r_ff <= snap_r;
         snap_l_ff <= snap_l;
      end
      if (o_load) begin
         period_r_ff <= snap_r_ff.period;
         new_r_ff    <= snap_r_ff.fresh;
         edges_r_ff  <= snap_r_ff.edges;
         period_l_ff <= snap_l_ff.period;
         new_l_ff    <= snap_l_ff.fresh;
         edges_l_ff  <= snap_l_ff.edges;
      end
   end

   assign rsp_chan.valid             = o_valid_ff;
   assign rsp_chan.period_right      = period_r_ff;
   assign rsp_chan.average_right     = avg_r_ff;
   assign rsp_chan.average_new_right = new_r_ff;
   assign rsp_chan.edges_right       = edges_r_ff;
   assign rsp_chan.period_left       = period_l_ff;
   assign rsp_chan.average_left      = avg_l_ff;
   assign rsp_chan.average_new_left  = new_l_ff;
   assign rsp_chan.edges_left        = edges_l_ff;

endmodule

`default_nettype wire

>>> hw/rtl/dept_channel.sv
// dept_channel: running count, period, saturating sum, fill and edge count of one wheel
// depends on dept_pkg
`default_nettype none

module dept_channel (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic                           ovf,
   input  logic                           hit,
   input  logic [dept_pkg::CAP_USE_W-1:0] cap,
   input  logic [dept_pkg::STOP_W-1:0]    stop_limit,
   output dept_pkg::chan_snap_type        snap
);
   import dept_pkg::*;

   logic signed [RUN_W-1:0]     running_ff, running_in;
   logic signed [PER_W-1:0]     period_ff, period_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [EDGE_W-1:0]           edges_ff, edges_in;

   logic signed [RUN_EXT_W-1:0] run_ovf;
   logic signed [RUN_EXT_W-1:0] stop_ext;
   logic                        at_stop;
   logic signed [PER_W-1:0]     per_edge;
   logic signed [SUM_W:0]       sum_ext;
   logic signed [SUM_W-1:0]     sum_sat;
   logic                        last;

   always_comb begin
      run_ovf  = RUN_EXT_W'(running_ff) + OVF_STEP;
      stop_ext = $signed(RUN_EXT_W'(stop_limit));
      at_stop  = run_ovf >= stop_ext;
      per_edge = PER_W'(running_ff) + $signed(PER_W'(cap));
      sum_ext  = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(per_edge);
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
         sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         sum_sat = sum_ext[SUM_W-1:0];
      end
      last = (fill_ff == FILL_LAST);
   end

   always_comb begin
      running_in = running_ff;
      period_in  = period_ff;
      sum_in     = sum_ff;
      fill_in    = fill_ff;
      edges_in   = edges_ff;
      if (step_en) begin
         if (ovf) begin
            if (at_stop) begin
               running_in = RUN_W'(stop_limit);
               period_in  = PER_W'(stop_limit);
            end else begin
               running_in = run_ovf[RUN_W-1:0];
            end
         end else if (hit) begin
            edges_in   = edges_ff + EDGE_W'(1);
            period_in  = per_edge;
            running_in = -$signed(RUN_W'(cap));
            if (last) begin
               fill_in = '0;
               sum_in  = '0;
            end else begin
               fill_in = fill_ff + FILL_W'(1);
               sum_in  = sum_sat;
            end
         end
      end
   end

   always_comb begin
      snap.period = period_in;
      snap.edges  = edges_in;
      snap.sum    = sum_sat;
      snap.fresh  = step_en && !ovf && hit && last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         period_ff  <= '0;
         sum_ff     <= '0;
         fill_ff    <= '0;
         edges_ff   <= '0;
      end else begin
         running_ff <= running_in;
         period_ff  <= period_in;
         sum_ff     <= sum_in;
         fill_ff    <= fill_in;
         edges_ff   <= edges_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/dept_avg_div.sv
// dept_avg_div: sum divided by the average length, truncated toward zero
// depends on dept_pkg; reciprocal multiply, no divider
`default_nettype none

module dept_avg_div (
   input  logic signed [dept_pkg::SUM_W-1:0] sum,
   output logic signed [dept_pkg::PER_W-1:0] average
);
   import dept_pkg::*;

   logic              neg;
   logic [SUM_W-1:0]  mag;
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  quo;
   logic [SUM_W-1:0]  res;

   always_comb begin
      neg     = sum[SUM_W-1];
      mag     = neg ? SUM_W'(-sum) : SUM_W'(sum);
      prod    = PROD_W'(mag) * PROD_W'(AVG_RECIP);
      quo     = SUM_W'(prod >> AVG_SHIFT);
      res     = neg ? (~quo + SUM_W'(1)) : quo;
      average = $signed(res[PER_W-1:0]);
   end

endmodule

`default_nettype wire

>>> hw/rtl/dept_checker.sv
// dept_checker: port-level assertions on the tachometer top, with its bind
// depends on dept_pkg and dual_encoder_period_tachometer_top
`default_nettype none

module dept_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [dept_pkg::PER_W-1:0] rsp_period_right,
   input logic signed [dept_pkg::PER_W-1:0] rsp_period_left,
   input logic                          rsp_average_new_right,
   input logic                          rsp_average_new_left,
   input logic [dept_pkg::EDGE_W-1:0]   rsp_edges_right,
   input logic [dept_pkg::EDGE_W-1:0]   rsp_edges_left
);
   import dept_pkg::*;

   // stalled result holds its valid, periods and edge counts
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_period_right)
         && $stable(rsp_period_left) && $stable(rsp_edges_right) && $stable(rsp_edges_left))
      else $error("rsp payload changed while stalled");

   // one edge per item, so at most one wheel publishes an average
   a_one_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_average_new_right && rsp_average_new_left))
      else $error("both wheels report a new average");

   // rsp_valid rises only after a request transfer passed through stage 1
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without matching request transfer");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind dual_encoder_period_tachometer_top dept_checker u_dept_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_chan.valid),
   .req_ready             (req_chan.ready),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_period_right      (rsp_chan.period_right),
   .rsp_period_left       (rsp_chan.period_left),
   .rsp_average_new_right (rsp_chan.average_new_right),
   .rsp_average_new_left  (rsp_chan.average_new_left),
   .rsp_edges_right       (rsp_chan.edges_right),
   .rsp_edges_left        (rsp_chan.edges_left)
);

`default_nettype wire
